/* rtl/core/pxs_pkg.sv */
package pxs_pkg;

  // Default image limits, handed to the top level as parameter defaults.
  localparam int MaxColsDef = 1024;
  localparam int MaxRowsDef = 1024;

  // Field widths fixed by the interface.
  localparam int PixelW = 8;
  localparam int CoordW = 11;
  localparam int SizeW  = 11;
  localparam int CfgAddrW = 2;
  localparam int OutDataW = 32;

  // Register reset values.
  localparam logic [SizeW-1:0] SrcColsRst = SizeW'(1024);
  localparam logic [SizeW-1:0] SrcRowsRst = SizeW'(1024);

  typedef enum logic {
    MODE_UP   = 1'b0,
    MODE_DOWN = 1'b1
  } mode_e;

  typedef enum logic [CfgAddrW-1:0] {
    REG_MODE     = 2'd0,
    REG_SRC_COLS = 2'd1,
    REG_SRC_ROWS = 2'd2
  } reg_idx_e;

  // Index of the last of the four replicated results.
  localparam logic [1:0] UpLastIdx = 2'd3;

endpackage

/* rtl/core/pixel_scaler_2x_up_down.sv */
// Channel     | Direction | Contents
// ------------+-----------+-------------------------------------------------
// s_axis      | in        | tdata[7:0] = pixel, one source pixel per request
// m_axis      | out       | tdata = out_row, out_col, value; tlast = last
// cfg         | in        | cfg_addr_i = register index, cfg_data_i = value
//
// Upscale: the single output register hands out the four replicated target
// pixels of each source pixel one per cycle while m_axis is not stalled.
// Downscale: pixels that complete no 2x2 block make no result.
// Reset clears the position counters, the held pixel and the registers; the
// line store is not cleared and is written before it is read in a normal image.
// A stalled m_axis holds the output register and, through it, the work stage.
module pixel_scaler_2x_up_down #(
  parameter int MAX_COLS = pxs_pkg::MaxColsDef,
  parameter int MAX_ROWS = pxs_pkg::MaxRowsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pxs_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [pxs_pkg::SizeW-1:0]     cfg_data_i,
  // source pixels
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [pxs_pkg::PixelW-1:0]    s_axis_tdata,   // [7:0] pixel
  // target pixels
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [pxs_pkg::OutDataW-1:0]  m_axis_tdata,   // [10:0] out_row,
                                                        // [21:11] out_col,
                                                        // [29:22] value, rest 0
  output logic                          m_axis_tlast    // last
);

  import pxs_pkg::*;

  localparam int ColW      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RowW      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int BaseW     = (ColW > RowW) ? ColW : RowW;
  // Wide enough for the size registers, the maxima and a counter plus one.
  localparam int CmpW      = ((BaseW > SizeW) ? BaseW : SizeW) + 1;
  localparam int LineDepth = (MAX_COLS + 1) / 2;
  localparam int LineAw    = (LineDepth > 1) ? $clog2(LineDepth) : 1;
  localparam int SumW      = PixelW + 1;
  // Target coordinates are built at this width before truncation to CoordW.
  localparam int TgtW      = ((BaseW > CoordW) ? BaseW : CoordW) + 1;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes must arrive only while the block is idle;
  // the block itself does not enforce this. The port is always ready.
  // ---------------------------------------------------------------------------
  mode_e            mode_q;
  logic [SizeW-1:0] src_cols_q, src_rows_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_UP;
      src_cols_q <= SrcColsRst;
      src_rows_q <= SrcRowsRst;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        REG_MODE:     mode_q     <= mode_e'(cfg_data_i[0]);
        REG_SRC_COLS: src_cols_q <= cfg_data_i;
        REG_SRC_ROWS: src_rows_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective sizes: zero counts as one, anything above the maximum as the
  // maximum.
  logic [CmpW-1:0] cols_eff, rows_eff, cols_ext, rows_ext;

  always_comb begin
    cols_ext = CmpW'(src_cols_q);
    rows_ext = CmpW'(src_rows_q);
    if (cols_ext == '0) begin
      cols_eff = CmpW'(1);
    end else if (cols_ext > CmpW'(MAX_COLS)) begin
      cols_eff = CmpW'(MAX_COLS);
    end else begin
      cols_eff = cols_ext;
    end
    if (rows_ext == '0) begin
      rows_eff = CmpW'(1);
    end else if (rows_ext > CmpW'(MAX_ROWS)) begin
      rows_eff = CmpW'(MAX_ROWS);
    end else begin
      rows_eff = rows_ext;
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake between the stages.
  // ---------------------------------------------------------------------------
  logic       s1_valid_q;
  logic       s1_last;
  logic       s1_adv;
  logic       out_load;
  logic       in_acc;

  assign out_load      = !m_axis_tvalid || m_axis_tready;
  assign s1_adv        = s1_valid_q && out_load;
  assign s_axis_tready = !s1_valid_q || (s1_adv && s1_last);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------------------
  // Position tracking and line store bookkeeping, done at the accepting edge.
  // ---------------------------------------------------------------------------
  logic [ColW-1:0]   col_q;
  logic [RowW-1:0]   row_q;
  logic [PixelW-1:0] held_q;
  logic [PixelW-1:0] px;
  logic [SumW-1:0]   pair_sum;
  logic [CmpW-1:0]   col_inc, row_inc;
  logic [LineAw-1:0] slot;
  logic              col_odd, row_odd;
  logic              emit_one;

  assign px       = s_axis_tdata;
  assign col_odd  = col_q[0];
  assign row_odd  = row_q[0];
  assign pair_sum = SumW'(held_q) + SumW'(px);
  assign col_inc  = CmpW'(col_q) + CmpW'(1);
  assign row_inc  = CmpW'(row_q) + CmpW'(1);
  assign slot     = LineAw'(col_q >> 1);
  assign emit_one = (mode_q == MODE_UP) || (row_odd && col_odd);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      held_q <= '0;
    end else if (in_acc) begin
      if (!col_odd) begin
        held_q <= px;
      end
      if (col_inc >= cols_eff) begin
        col_q <= '0;
        if (row_inc >= rows_eff) begin
          row_q <= '0;
        end else begin
          row_q <= RowW'(row_inc);
        end
      end else begin
        col_q <= ColW'(col_inc);
      end
    end
  end

  // Even rows write the pair sum of each column pair; odd rows read it back.
  // Both happen on the accepting edge, so the read data stays put while the
  // item sits in the work stage.
  logic [SumW-1:0] line_rdata;

  pxs_line_mem #(
    .Depth (LineDepth),
    .AddrW (LineAw),
    .DataW (SumW)
  ) u_line_mem (
    .clk_i   (clk_i),
    .wr_en_i (in_acc && col_odd && !row_odd),
    .rd_en_i (in_acc && col_odd && row_odd),
    .addr_i  (slot),
    .wdata_i (pair_sum),
    .rdata_o (line_rdata)
  );

  // ---------------------------------------------------------------------------
  // Work stage: holds one accepted item and walks through its results.
  // ---------------------------------------------------------------------------
  mode_e             s1_mode_q;
  logic [CoordW-1:0] s1_row_q, s1_col_q;
  logic [PixelW-1:0] s1_pix_q;
  logic [SumW-1:0]   s1_psum_q;
  logic [1:0]        s1_idx_q;
  logic [TgtW-1:0]   tgt_row, tgt_col;

  always_comb begin
    if (mode_q == MODE_UP) begin
      tgt_row = TgtW'(row_q) << 1;
      tgt_col = TgtW'(col_q) << 1;
    end else begin
      tgt_row = TgtW'(row_q) >> 1;
      tgt_col = TgtW'(col_q) >> 1;
    end
  end

  assign s1_last = (s1_mode_q == MODE_DOWN) || (s1_idx_q == UpLastIdx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_idx_q   <= '0;
    end else if (in_acc) begin
      s1_valid_q <= emit_one;
      s1_idx_q   <= '0;
    end else if (s1_adv) begin
      s1_valid_q <= !s1_last;
      s1_idx_q   <= s1_idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_mode_q <= mode_q;
      s1_row_q  <= tgt_row[CoordW-1:0];
      s1_col_q  <= tgt_col[CoordW-1:0];
      s1_pix_q  <= px;
      s1_psum_q <= pair_sum;
    end
  end

  // Result for the current index: replicated pixel, or the 2x2 block average.
  logic [CoordW-1:0] res_row, res_col;
  logic [PixelW-1:0] res_val;
  logic [SumW:0]     block_sum;

  assign block_sum = (SumW + 1)'(s1_psum_q) + (SumW + 1)'(line_rdata);

  always_comb begin
    if (s1_mode_q == MODE_UP) begin
      res_row = s1_row_q | CoordW'(s1_idx_q[1]);
      res_col = s1_col_q | CoordW'(s1_idx_q[0]);
      res_val = s1_pix_q;
    end else begin
      res_row = s1_row_q;
      res_col = s1_col_q;
      res_val = block_sum[SumW:2];
    end
  end

  // ---------------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------------
  logic              out_valid_q;
  logic [CoordW-1:0] out_row_q, out_col_q;
  logic [PixelW-1:0] out_val_q;
  logic              out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_row_q  <= res_row;
      out_col_q  <= res_col;
      out_val_q  <= res_val;
      out_last_q <= s1_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'({out_val_q, out_col_q, out_row_q});
  assign m_axis_tlast  = out_last_q;

endmodule

/* rtl/core/pxs_line_mem.sv */
module pxs_line_mem #(
  parameter int Depth = 512,
  parameter int AddrW = 9,
  parameter int DataW = 9
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [DataW-1:0] wdata_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
